### rtl/wrkv_pkg.sv
// Shared constants, types and structs of the write-recency key-value cache.
package wrkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = IDX_W + 1;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [IDX_W-1:0] t_rank;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // valid bit and recency rank of the entry under the scan pointer
    typedef struct packed {
        logic  valid;
        t_rank rank;
    } t_entry_view;

    // outcome of one scan over all entries
    typedef struct packed {
        logic              found;
        t_idx              hit_idx;
        t_rank             hit_rank;
        logic [DATA_W-1:0] hit_data;
        logic              free_found;
        t_idx              free_idx;
        logic              best_found;
        t_idx              best_idx;
        t_rank             best_rank;
    } t_scan_res;

    // recency update request: promote slot, age entries ranked below limit
    typedef struct packed {
        logic             en;
        t_idx             slot;
        logic [CNT_W-1:0] limit;
        logic             fill;
    } t_upd;

endpackage

### rtl/wrkv_store.sv
// Key and value memory of the cache: one write port, one registered read port.
module wrkv_store (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  wrkv_pkg::t_idx             i_rd_addr,
    output logic [wrkv_pkg::KEY_W-1:0]  o_rd_key,
    output logic [wrkv_pkg::DATA_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  wrkv_pkg::t_idx             i_wr_addr,
    input  logic [wrkv_pkg::KEY_W-1:0]  i_wr_key,
    input  logic [wrkv_pkg::DATA_W-1:0] i_wr_data
);
    import wrkv_pkg::*;

    logic [KEY_W-1:0]  r_key_mem  [ENTRIES];
    logic [DATA_W-1:0] r_data_mem [ENTRIES];
    logic [KEY_W-1:0]  r_rd_key;
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[i_wr_addr]  <= i_wr_key;
            r_data_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_key  <= r_key_mem[i_rd_addr];
            r_rd_data <= r_data_mem[i_rd_addr];
        end
    end

    assign o_rd_key  = r_rd_key;
    assign o_rd_data = r_rd_data;

endmodule

### rtl/wrkv_scan.sv
// Shared per-entry compare unit: key match, first free slot, oldest rank.
module wrkv_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_chk_en,
    input  wrkv_pkg::t_idx              i_chk_idx,
    input  logic [wrkv_pkg::KEY_W-1:0]  i_key,
    input  logic [wrkv_pkg::KEY_W-1:0]  i_rd_key,
    input  logic [wrkv_pkg::DATA_W-1:0] i_rd_data,
    input  wrkv_pkg::t_entry_view       i_view,
    output wrkv_pkg::t_scan_res         o_res
);
    import wrkv_pkg::*;

    t_scan_res r_res;
    t_scan_res n_res;

    always_comb begin
        n_res = r_res;
        if (i_start) begin
            n_res.found      = 1'b0;
            n_res.free_found = 1'b0;
            n_res.best_found = 1'b0;
        end else if (i_chk_en) begin
            if (i_view.valid && (i_rd_key == i_key) && !r_res.found) begin
                n_res.found    = 1'b1;
                n_res.hit_idx  = i_chk_idx;
                n_res.hit_rank = i_view.rank;
                n_res.hit_data = i_rd_data;
            end
            if (!i_view.valid && !r_res.free_found) begin
                n_res.free_found = 1'b1;
                n_res.free_idx   = i_chk_idx;
            end
            // later entries win ties
            if (i_view.valid && (!r_res.best_found || (i_view.rank >= r_res.best_rank))) begin
                n_res.best_found = 1'b1;
                n_res.best_idx   = i_chk_idx;
                n_res.best_rank  = i_view.rank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/wrkv_table.sv
// Valid bits, recency ranks and fill count of the cache entries.
module wrkv_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wrkv_pkg::t_idx             i_rd_idx,
    output wrkv_pkg::t_entry_view      o_view,
    input  wrkv_pkg::t_upd             i_upd,
    output logic [wrkv_pkg::CNT_W-1:0] o_used
);
    import wrkv_pkg::*;

    logic [ENTRIES-1:0] r_valid;
    t_rank              r_rank [ENTRIES];
    logic [CNT_W-1:0]   r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
        end else if (i_upd.en && i_upd.fill) begin
            r_valid[i_upd.slot] <= 1'b1;
            r_used              <= r_used + 1'b1;
        end
    end

    // promote: updated slot becomes rank zero, younger valid entries age by one
    always_ff @(posedge i_clk) begin
        if (i_upd.en) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_W'(i) == i_upd.slot) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (CNT_W'(r_rank[i]) < i_upd.limit)) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
        end
    end

    assign o_view.valid = r_valid[i_rd_idx];
    assign o_view.rank  = r_rank[i_rd_idx];
    assign o_used       = r_used;

    a_used_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_used))
        else $error("fill count disagrees with valid bits");

    a_promoted_rank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd.en |=> (r_rank[$past(i_upd.slot)] == '0))
        else $error("promoted slot does not hold rank zero");

endmodule

### rtl/write_recency_kv_cache_core.sv
// Top level of the write-recency key-value cache: sequencer, config and output stage.
//
// Usage:
//   Input stream (s_axis): tuser carries the command (0 get, 1 set); tdata
//   carries key in bits 31:0 and value in bits 63:32. An item is taken when
//   tvalid and tready are both high.
//   Output stream (m_axis): one item per get. tuser is the hit flag, tdata the
//   stored value on a hit or all ones on a miss. A set produces no item.
//   Config: the user writes capacity by i_cfg_we / i_cfg_wdata only while idle (not
//   enforced by the block); zero acts as one, values above the entry count saturate.
// Timing:
//   Every item walks all 16 entries, one per cycle, through one shared compare
//   unit behind the registered memory read, then commits: tready stays low from
//   acceptance until the commit is done, so a new item is taken only after the last
//   one has committed; a get result is loaded into the output register at commit.
//   The single memory read port and the per-entry compare make the scan serial.
// Reset: synchronous, active low. All entries become invalid, capacity
//   returns to 16 and no output item is pending.
// Stall: a result waits in the output register; the next item is already
//   accepted and scanned, and a get holds in commit until the register frees.
module write_recency_kv_cache_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [wrkv_pkg::CAP_W-1:0]          i_cfg_wdata,  // capacity
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [wrkv_pkg::KEY_W+wrkv_pkg::DATA_W-1:0] i_s_axis_tdata, // key, value
    input  logic                               i_s_axis_tuser,  // cmd
    // output stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [wrkv_pkg::DATA_W-1:0]         o_m_axis_tdata,  // read_value
    output logic                               o_m_axis_tuser   // hit
);
    import wrkv_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic              r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_value;
    logic [CNT_W-1:0]  r_addr;
    logic              r_chk_en;
    t_idx              r_chk_idx;
    logic [CAP_W-1:0]  r_cap;
    logic              r_out_valid;
    logic              r_out_hit;
    logic [DATA_W-1:0] r_out_data;

    logic              w_accept;
    logic              w_issue;
    logic              w_scan_done;
    logic              w_out_load;
    logic [KEY_W-1:0]  w_rd_key;
    logic [DATA_W-1:0] w_rd_data;
    t_entry_view       w_view;
    t_scan_res         w_res;
    t_upd              w_upd;
    logic [CNT_W-1:0]  w_used;
    logic [CMP_W-1:0]  w_cap_ext;
    logic [CMP_W-1:0]  w_cap_eff;
    logic              w_insert;

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_issue     = (r_state == ST_SCAN) && (r_addr != CNT_W'(ENTRIES));
    assign w_scan_done = (r_state == ST_SCAN) && (r_addr == CNT_W'(ENTRIES));

    // effective capacity: zero acts as one, saturate at the entry count
    assign w_cap_ext = CMP_W'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            w_cap_eff = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(ENTRIES)) begin
            w_cap_eff = CMP_W'(ENTRIES);
        end else begin
            w_cap_eff = w_cap_ext;
        end
    end
    assign w_insert = CMP_W'(w_used) < w_cap_eff;

    // sequencer
    always_comb begin
        n_state    = r_state;
        w_out_load = 1'b0;
        w_upd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (r_cmd == CMD_GET) begin
                    // hold until the output register can take the result
                    if (!r_out_valid || i_m_axis_tready) begin
                        w_out_load = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    w_upd.en = 1'b1;
                    if (w_res.found) begin
                        w_upd.slot  = w_res.hit_idx;
                        w_upd.limit = CNT_W'(w_res.hit_rank);
                    end else if (w_insert) begin
                        w_upd.slot  = w_res.free_idx;
                        w_upd.limit = CNT_W'(ENTRIES);
                        w_upd.fill  = 1'b1;
                    end else begin
                        // evict the least recently set entry
                        w_upd.slot  = w_res.best_idx;
                        w_upd.limit = CNT_W'(w_res.best_rank);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_chk_en <= 1'b0;
            r_addr   <= '0;
        end else begin
            r_state  <= n_state;
            r_chk_en <= w_issue;
            if (w_accept) begin
                r_addr <= '0;
            end else if (w_issue) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    // item capture and compare-stage index
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_s_axis_tuser;
            r_key   <= i_s_axis_tdata[KEY_W-1:0];
            r_value <= i_s_axis_tdata[KEY_W+DATA_W-1:KEY_W];
        end
        r_chk_idx <= r_addr[IDX_W-1:0];
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // output register: the result waits here while the next item proceeds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_hit  <= w_res.found;
            r_out_data <= w_res.found ? w_res.hit_data : {DATA_W{1'b1}};
        end
    end

    wrkv_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_addr[IDX_W-1:0]),
        .o_rd_key  (w_rd_key),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_upd.en),
        .i_wr_addr (w_upd.slot),
        .i_wr_key  (r_key),
        .i_wr_data (r_value)
    );

    wrkv_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_chk_idx),
        .o_view   (w_view),
        .i_upd    (w_upd),
        .o_used   (w_used)
    );

    wrkv_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_chk_en  (r_chk_en),
        .i_chk_idx (r_chk_idx),
        .i_key     (r_key),
        .i_rd_key  (w_rd_key),
        .i_rd_data (w_rd_data),
        .i_view    (w_view),
        .o_res     (w_res)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_hit;

    a_result_from_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past((r_state == ST_COMMIT) && (r_cmd == CMD_GET)))
        else $error("output item raised without a get commit");

    a_insert_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd.en && w_upd.fill) |-> w_res.free_found)
        else $error("insert chosen but scan found no free slot");

endmodule

### tb/write_recency_kv_cache_core_test.sv
`timescale 1ns / 100ps
// Self-checking regression bench for the write-recency key-value cache core.
module write_recency_kv_cache_core_test;
    import wrkv_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 6;
    // a set gives no result to wait on
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 125;

    // what a get is expected to return
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] value;
    } t_lookup;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                    i_clk     = 1'b0;
    logic                    i_rst_n   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CAP_W-1:0]        cfg_wdata = '0;
    logic                    s_valid   = 1'b0;
    logic [KEY_W+DATA_W-1:0] s_data    = '0;   // key, value
    logic                    s_cmd     = CMD_GET;
    logic                    m_ready   = 1'b0;

    logic                    s_ready;
    logic                    m_valid;
    logic [DATA_W-1:0]       m_data;           // read_value
    logic                    m_hit;            // hit

    always #(HALF_PERIOD) i_clk = ~i_clk;

    write_recency_kv_cache_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_cmd),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_hit)
    );

    // ------------------------------------------------------------------
    // Cache predictor: its own copy of the slots, recency ages and capacity
    // ------------------------------------------------------------------
    logic              slot_live [ENTRIES];
    logic [KEY_W-1:0]  slot_key  [ENTRIES];
    logic [DATA_W-1:0] slot_data [ENTRIES];
    int unsigned       slot_age  [ENTRIES];   // 0 is the most recently set
    int unsigned       live_count;
    logic [CAP_W-1:0]  capacity;

    t_lookup     pending_lookups [$];         // gets accepted, result not yet seen

    int          send_idle_pct;
    int          recv_stall_pct;
    int          errors;
    int          sent_items;
    int          sent_gets;
    int          predicted_hits;
    int          evictions;
    int          lookups_checked;
    int          cap_writes;

    function automatic void model_clear();
        for (int i = 0; i < ENTRIES; i++) begin
            slot_live[i] = 1'b0;
            slot_key[i]  = '0;
            slot_data[i] = '0;
            slot_age[i]  = 0;
        end
        live_count = 0;
        capacity   = CAP_RESET;
    endfunction

    function automatic int model_find(logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    // Make slot s the newest; every other live slot younger than limit ages by one.
    function automatic void model_touch(int s, int unsigned limit);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && i != s && slot_age[i] < limit)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function automatic t_lookup model_lookup(logic [KEY_W-1:0] key);
        t_lookup res;
        int      s;
        s = model_find(key);
        res.hit   = (s >= 0);
        res.value = (s >= 0) ? slot_data[s] : '1;
        return res;
    endfunction

    function automatic void model_store(logic [KEY_W-1:0] key, logic [DATA_W-1:0] val);
        int          s;
        int unsigned cap;
        int unsigned oldest;
        s = model_find(key);
        // zero acts as one, anything past the slot count saturates
        cap = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
        if (s >= 0) begin
            slot_data[s] = val;
            model_touch(s, slot_age[s]);
            return;
        end
        if (live_count < cap) begin
            for (int i = 0; i < ENTRIES; i++)
                if (!slot_live[i] && s < 0)
                    s = i;
            slot_live[s] = 1'b1;
            slot_age[s]  = 0;
            live_count++;
            model_touch(s, ENTRIES);
        end else begin
            // evict the least recently set slot; live_count stays as it is
            oldest = 0;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_live[i] && (s < 0 || slot_age[i] >= oldest)) begin
                    s      = i;
                    oldest = slot_age[i];
                end
            model_touch(s, oldest);
            evictions++;
        end
        slot_key[s]  = key;
        slot_data[s] = val;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and result checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        errors++;
        $display("%0t: mismatch on %s (lookup %0d): expected %h, got %h",
                 $time, what, lookups_checked, want, got);
    endtask

    // Receiver side: stall at random at the rate of the current phase.
    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare every accepted result with the oldest pending lookup.
    always @(posedge i_clk) begin
        t_lookup want;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_lookups.size() == 0) begin
                flag_mismatch("result with no get pending", '0, m_data);
            end else begin
                want = pending_lookups.pop_front();
                if (m_hit !== want.hit)
                    flag_mismatch("hit", DATA_W'(want.hit), DATA_W'(m_hit));
                if (m_data !== want.value)
                    flag_mismatch("read_value", want.value, m_data);
                lookups_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present one item, wait for its handshake and predict its outcome.
    // Valid is left high; the next call or a drain decides whether it drops.
    task automatic send_item(logic cmd, logic [KEY_W-1:0] key, logic [DATA_W-1:0] val);
        t_lookup want;
        int      gap;
        gap = 0;
        if (send_idle_pct != 0) begin
            while ($urandom_range(99) < send_idle_pct)
                gap++;
            // now and then a longer pause so gaps land on every scan phase
            if ($urandom_range(7) == 0)
                gap += $urandom_range(24);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {val, key};
        s_cmd   <= cmd;
        @(posedge i_clk);
        while (s_ready !== 1'b1) @(posedge i_clk);
        sent_items++;
        if (cmd == CMD_GET) begin
            want = model_lookup(key);
            pending_lookups.push_back(want);
            sent_gets++;
            if (want.hit)
                predicted_hits++;
        end else begin
            model_store(key, val);
        end
    endtask

    // Drop valid, wait for every pending result, then let a trailing set finish.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        capacity   = cap;
        cap_writes++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty cache misses, then extreme keys and values round-trip at the reset capacity.
    task automatic test_extreme_keys();
        send_item(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(CMD_SET, 32'h0000_0000, 32'h0000_0000);
        // a stored -1 must still come back as a hit
        send_item(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_item(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // Overwrite a present key: new value, and it becomes the newest entry.
    task automatic test_overwrite();
        send_item(CMD_SET, 32'h8000_0000, 32'h1234_5678);
        send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    endtask

    // Capacity zero, capacity below the live count, re-insert of an evicted key, saturation.
    task automatic test_capacity_limits();
        write_capacity(5'd0);
        send_item(CMD_SET, 32'h0000_0005, 32'h0000_0005);
        send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(CMD_GET, 32'h0000_0005, 32'h0000_0000);
        send_item(CMD_SET, 32'h7FFF_FFFF, 32'hA5A5_5A5A);
        send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        write_capacity(5'd31);
        send_item(CMD_SET, 32'h0000_0006, 32'hFFFF_0000);
        send_item(CMD_GET, 32'h0000_0006, 32'h0000_0000);
        send_item(CMD_GET, 32'h0000_0005, 32'h0000_0000);
    endtask

    // One random phase: mostly keys from a pool a little larger than the capacity,
    // so hits, overwrites and evictions all happen; the rest are fresh keys.
    task automatic run_phase(logic [CAP_W-1:0] cap, int idle_pct, int stall_pct);
        logic [KEY_W-1:0] key_pool [$];
        logic [KEY_W-1:0] key;
        int               eff_cap;
        int               pool_n;
        write_capacity(cap);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        eff_cap = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
        pool_n  = eff_cap + $urandom_range(1, 6);
        for (int i = 0; i < pool_n; i++) begin
            case ($urandom_range(9))
                0:       key_pool.push_back(32'h8000_0000);
                1:       key_pool.push_back(32'h7FFF_FFFF);
                default: key_pool.push_back($urandom);
            endcase
        end
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(9) < 8)
                key = key_pool[$urandom_range(pool_n - 1)];
            else
                key = $urandom;
            send_item($urandom_range(1) ? CMD_SET : CMD_GET, key, $urandom);
        end
    endtask

    task automatic test_random_traffic();
        run_phase(5'd16, 0, 0);
        run_phase(5'd1, 65, 0);
        run_phase(5'd4, 0, 65);
        run_phase(5'd31, 31, 31);
        run_phase(5'd0, 0, 0);
        run_phase(CAP_W'($urandom_range(2, 15)), 65, 0);
        run_phase(CAP_W'($urandom_range(17, 30)), 0, 65);
        run_phase(CAP_W'($urandom_range(31)), 31, 31);
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, run the tests, settle, report
    // ------------------------------------------------------------------
    initial begin
        errors          = 0;
        sent_items      = 0;
        sent_gets       = 0;
        predicted_hits  = 0;
        evictions       = 0;
        lookups_checked = 0;
        cap_writes      = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        model_clear();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_keys();
        test_overwrite();
        test_capacity_limits();
        test_random_traffic();
        drain();

        $display("covered %0d items (%0d gets, %0d predicted hits, %0d evictions)",
                 sent_items, sent_gets, predicted_hits, evictions);
        $display("checked %0d results over %0d capacity writes, %0d mismatches",
                 lookups_checked, cap_writes, errors);
        if (errors == 0)
            $display("write_recency_kv_cache_core regression: pass");
        else
            $display("write_recency_kv_cache_core regression: fail");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("timeout with %0d results still pending", pending_lookups.size());
        $display("write_recency_kv_cache_core regression: fail");
        $finish;
    end

endmodule
